/* hdl/srts_pkg.sv */
// ----------------------------------------------------------------------------
// srts_pkg
// Shared constants, codes and types of the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package srts_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int TIME_BITS_DEF = 16;

   localparam int OUT_W      = 16;
   localparam int SLOT_W     = 4;
   localparam int CNT_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CNT_W-1:0] PCOUNT_RESET = 5'd1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam int REG_PROCESS_COUNT = 0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic found;
      logic nz_any;
      logic nz_many;
   } pick_flags_type;

endpackage

`default_nettype wire

/* hdl/srts_pick.sv */
// ----------------------------------------------------------------------------
// srts_pick
// Running minimum over the slot entries streamed out of the table memory.
// Keeps the eligible slot with the least remaining time (lowest slot on ties)
// and counts slots with time left, saturating at two.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_pick #(
   parameter int IDX_W     = 4,
   parameter int TIME_BITS = srts_pkg::TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic                  ent_valid,
   input  wire logic [IDX_W-1:0]      ent_idx,
   input  wire logic [TIME_BITS-1:0]  ent_arrival,
   input  wire logic [TIME_BITS-1:0]  ent_burst,
   input  wire logic [TIME_BITS-1:0]  ent_remaining,
   input  wire logic [TIME_BITS-1:0]  now,
   output srts_pkg::pick_flags_type   flags,
   output logic      [IDX_W-1:0]      best_idx,
   output logic      [TIME_BITS-1:0]  best_arrival,
   output logic      [TIME_BITS-1:0]  best_burst,
   output logic      [TIME_BITS-1:0]  best_remaining
);

   srts_pkg::pick_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0]     idx_ff;
   logic [TIME_BITS-1:0] arr_ff, burst_ff, rem_ff;
   logic                 live;
   logic                 take;

   always_comb begin
      live = ent_valid && (ent_remaining != '0);
      take = live && (ent_arrival <= now) && (!flags_ff.found || (ent_remaining < rem_ff));
      flags_in = flags_ff;
      if (clear) begin
         flags_in = '0;
      end else begin
         if (take) begin
            flags_in.found = 1'b1;
         end
         if (live) begin
            flags_in.nz_many = flags_ff.nz_many || flags_ff.nz_any;
            flags_in.nz_any  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !clear) begin
         idx_ff   <= ent_idx;
         arr_ff   <= ent_arrival;
         burst_ff <= ent_burst;
         rem_ff   <= ent_remaining;
      end
   end

   assign flags          = flags_ff;
   assign best_idx       = idx_ff;
   assign best_arrival   = arr_ff;
   assign best_burst     = burst_ff;
   assign best_remaining = rem_ff;

endmodule

`default_nettype wire

/* hdl/shortest_remaining_time_scheduler_top.sv */
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_top
// Preemptive shortest-remaining-time scheduler over a table of process slots.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low. A load item (mode 0) writes one
//   slot's arrival and burst time in the accepting cycle and clears the clock;
//   busy stays low and no result follows. A tick item (mode 1) raises busy.
//   The slot table sits in one synchronous memory (arrival, burst, remaining).
//   A tick reads the counted slots one per cycle through the single read
//   port, then writes back the picked slot and updates the clock. The result
//   shows on the rsp_ ports for one cycle with rsp_valid, after the scan, the
//   drain state and the update state. In that result cycle busy is low again,
//   so a new item can be taken then; a load is taken in its accepting cycle.
//   The read port walk over the counted slots sets the tick rate.
//   Results cannot be held off by the receiver.
//   Reset clears the clock to zero, the process count to one and the control
//   state; the slot table holds nothing defined until slots are loaded.
//   process_count reads at APB byte address 0; a write at any address sets it.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_remaining_time_scheduler_top #(
   parameter int MAX_PROCS = srts_pkg::MAX_PROCS_DEF,
   parameter int TIME_BITS = srts_pkg::TIME_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_mode,
   input  wire logic [srts_pkg::SLOT_W-1:0]       req_slot,
   input  wire logic [srts_pkg::OUT_W-1:0]        req_arrival_time,
   input  wire logic [srts_pkg::OUT_W-1:0]        req_burst_time,
   // result channel
   output logic                                   rsp_valid,
   output logic                                   rsp_ran_valid,
   output logic      [srts_pkg::SLOT_W-1:0]       rsp_ran_slot,
   output logic                                   rsp_finished,
   output logic      [srts_pkg::OUT_W-1:0]        rsp_finish_time,
   output logic      [srts_pkg::OUT_W-1:0]        rsp_turnaround,
   output logic      [srts_pkg::OUT_W-1:0]        rsp_waiting,
   output logic                                   rsp_all_done,
   // configuration
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [srts_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [srts_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [srts_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int ENT_W = 3 * TIME_BITS;

   srts_pkg::state_type state_ff, state_in;

   logic [srts_pkg::CNT_W-1:0] pcount_ff;
   logic [TIME_BITS-1:0]       time_ff;
   logic [TIME_BITS-1:0]       time_plus_ff;
   logic [IDX_W-1:0]           issue_idx_ff;
   logic [IDX_W-1:0]           last_idx;

   logic [ENT_W-1:0]           entry_mem [MAX_PROCS];
   logic [ENT_W-1:0]           rd_data_ff;
   logic                       rd_valid_ff;
   logic [IDX_W-1:0]           rd_tag_ff;
   logic                       rd_en;

   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   logic [ENT_W-1:0]           mem_wdata;

   logic                       accept;
   logic                       load_go;
   logic                       tick_go;
   logic                       csr_write;

   srts_pkg::pick_flags_type   flags;
   logic [IDX_W-1:0]           best_idx;
   logic [TIME_BITS-1:0]       best_arr, best_burst, best_rem;
   logic                       fin_now;

   logic                       fin_ff;
   logic                       done_ff;
   logic [TIME_BITS-1:0]       tat_ff;
   logic [TIME_BITS-1:0]       wait_val;

   logic [TIME_BITS-1:0]       load_arr, load_burst;

   // ---------------- handshakes ----------------
   assign accept    = start && !busy;
   assign load_go   = accept && (req_mode == srts_pkg::MODE_LOAD)
                      && (32'(req_slot) < MAX_PROCS);
   assign tick_go   = accept && (req_mode == srts_pkg::MODE_TICK);
   assign csr_write = psel && penable && pwrite && pready;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= srts_pkg::PCOUNT_RESET;
      end else if (csr_write) begin
         pcount_ff <= pwdata[srts_pkg::CNT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == srts_pkg::CSR_ADDR_W'(srts_pkg::REG_PROCESS_COUNT * 4))
                   ? srts_pkg::CSR_DATA_W'(pcount_ff) : '0;

   // last counted slot, count clamped to 1..MAX_PROCS
   always_comb begin
      if (pcount_ff == '0) begin
         last_idx = '0;
      end else if (32'(pcount_ff) > MAX_PROCS) begin
         last_idx = IDX_W'(MAX_PROCS - 1);
      end else begin
         last_idx = IDX_W'(pcount_ff - srts_pkg::CNT_W'(1));
      end
   end

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srts_pkg::ST_IDLE,
         srts_pkg::ST_REPORT: begin
            if (tick_go) begin
               state_in = srts_pkg::ST_SCAN;
            end else begin
               state_in = srts_pkg::ST_IDLE;
            end
         end
         srts_pkg::ST_SCAN: begin
            if (issue_idx_ff == last_idx) begin
               state_in = srts_pkg::ST_DRAIN;
            end
         end
         srts_pkg::ST_DRAIN:  state_in = srts_pkg::ST_UPDATE;
         srts_pkg::ST_UPDATE: state_in = srts_pkg::ST_REPORT;
         default:             state_in = srts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         srts_pkg::ST_IDLE:   busy = 1'b0;
         srts_pkg::ST_REPORT: begin
            busy      = 1'b0;
            rsp_valid = 1'b1;
         end
         srts_pkg::ST_SCAN:   rd_en = 1'b1;
         default:             busy  = 1'b1;
      endcase
   end

   // ---------------- scan address ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_idx_ff <= '0;
      end else if (tick_go) begin
         issue_idx_ff <= '0;
      end else if (rd_en && (issue_idx_ff != last_idx)) begin
         issue_idx_ff <= issue_idx_ff + IDX_W'(1);
      end
   end

   // ---------------- slot table ----------------
   assign load_arr   = TIME_BITS'(req_arrival_time);
   assign load_burst = TIME_BITS'(req_burst_time);
   assign fin_now    = flags.found && (best_rem == TIME_BITS'(1));

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx;
      mem_wdata = {best_arr, best_burst, best_rem - TIME_BITS'(1)};
      if (load_go) begin
         mem_we    = 1'b1;
         mem_waddr = IDX_W'(req_slot);
         mem_wdata = {load_arr, load_burst, load_burst};
      end else if ((state_ff == srts_pkg::ST_UPDATE) && flags.found) begin
         mem_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[issue_idx_ff];
         rd_tag_ff  <= issue_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   srts_pick #(
      .IDX_W     (IDX_W),
      .TIME_BITS (TIME_BITS)
   ) u_pick (
      .clock          (clock),
      .reset          (reset),
      .clear          (tick_go),
      .ent_valid      (rd_valid_ff),
      .ent_idx        (rd_tag_ff),
      .ent_arrival    (rd_data_ff[ENT_W-1 -: TIME_BITS]),
      .ent_burst      (rd_data_ff[2*TIME_BITS-1 -: TIME_BITS]),
      .ent_remaining  (rd_data_ff[TIME_BITS-1:0]),
      .now            (time_ff),
      .flags          (flags),
      .best_idx       (best_idx),
      .best_arrival   (best_arr),
      .best_burst     (best_burst),
      .best_remaining (best_rem)
   );

   // ---------------- clock and finish bookkeeping ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (load_go) begin
         time_ff <= '0;
      end else if (state_ff == srts_pkg::ST_UPDATE) begin
         time_ff <= time_plus_ff;
      end
   end

   // saturating increment, taken once per tick before the scan
   always_ff @(posedge clock) begin
      if (tick_go) begin
         time_plus_ff <= (time_ff == '1) ? time_ff : time_ff + TIME_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (state_ff == srts_pkg::ST_UPDATE) begin
         fin_ff  <= fin_now;
         done_ff <= !flags.nz_any || (!flags.nz_many && fin_now);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == srts_pkg::ST_UPDATE) begin
         tat_ff <= (time_plus_ff > best_arr) ? time_plus_ff - best_arr : '0;
      end
   end

   assign wait_val = (tat_ff > best_burst) ? tat_ff - best_burst : '0;

   // ---------------- result ----------------
   assign rsp_ran_valid   = flags.found;
   assign rsp_ran_slot    = flags.found ? srts_pkg::SLOT_W'(best_idx) : '0;
   assign rsp_finished    = fin_ff;
   assign rsp_finish_time = fin_ff ? srts_pkg::OUT_W'(time_ff) : '0;
   assign rsp_turnaround  = fin_ff ? srts_pkg::OUT_W'(tat_ff) : '0;
   assign rsp_waiting     = fin_ff ? srts_pkg::OUT_W'(wait_val) : '0;
   assign rsp_all_done    = done_ff;

endmodule

`default_nettype wire

/* hdl/srts_check.sv */
// ----------------------------------------------------------------------------
// srts_check
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_check (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_mode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ran_valid,
   input wire logic                          rsp_finished,
   input wire logic [srts_pkg::OUT_W-1:0]    rsp_finish_time,
   input wire logic [srts_pkg::OUT_W-1:0]    rsp_turnaround
);

   // results are single-cycle strobes spaced by the scan
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a tick keeps the block busy for the next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == srts_pkg::MODE_TICK)) |=> (busy && !rsp_valid))
      else $error("tick accepted without entering the scan");

   // a load never makes the block busy
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == srts_pkg::MODE_LOAD)) |=> !busy)
      else $error("load item stalled the channel");

   // only a running slot can finish, and idle fields stay zero
   a_finish_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_finished) |-> ((rsp_finish_time == '0) && (rsp_turnaround == '0)))
      else $error("finish fields set without a finished slot");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> rsp_ran_valid)
      else $error("finished reported on an idle tick");

endmodule

bind shortest_remaining_time_scheduler_top srts_check u_srts_check (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_ran_valid   (rsp_ran_valid),
   .rsp_finished    (rsp_finished),
   .rsp_finish_time (rsp_finish_time),
   .rsp_turnaround  (rsp_turnaround)
);

`default_nettype wire
